// ===== hw/rtl/cpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpwm_pkg
// Shared types and constants for the causal patch window mean block.
// ----------------------------------------------------------------------------
package cpwm_pkg;

    localparam int VALUE_W = 16;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SLICES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] patch_value;
        logic               last_of_patch;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] voxel_mean;
        logic               last_voxel;
        logic               patch_overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_back_state;

endpackage

// ===== hw/rtl/cpwm_front.sv =====
// ----------------------------------------------------------------------------
// cpwm_front
// Accumulates patch elements; on a closed patch pushes a job into a queue.
// ----------------------------------------------------------------------------
module cpwm_front #(
    parameter int PATCH_W = 10,
    parameter int SUM_W   = 26,
    parameter int POS_W   = 5,
    parameter int MAX_PATCH_ELEMS = 512,
    parameter int JOB_W   = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cpwm_pkg::t_in_item   i_item,
    input  logic [POS_W:0]       i_rows,
    input  logic [POS_W:0]       i_cols,
    input  logic [POS_W:0]       i_slices,
    output logic                 o_push,
    output logic [JOB_W-1:0]     o_job,
    input  logic                 i_full
);
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [PATCH_W:0]   r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    logic [POS_W-1:0]   r_row, r_col, r_slc;
    logic               acc, cr, cc, cz, ovf_now;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;
    assign cr = ({1'b0, r_row} + 1'b1) >= i_rows;
    assign cc = ({1'b0, r_col} + 1'b1) >= i_cols;
    assign cz = ({1'b0, r_slc} + 1'b1) >= i_slices;

    always_comb begin
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        ovf_now = r_ovf;
        if (r_cnt < (PATCH_W+1)'(MAX_PATCH_ELEMS)) begin
            n_sum = r_sum + SUM_W'(i_item.patch_value);
            n_cnt = r_cnt + 1'b1;
        end else begin
            ovf_now = 1'b1;
        end
        n_ovf = ovf_now;
    end

    assign o_push = acc && i_item.last_of_patch;
    assign o_job  = JOB_W'({r_slc, r_col, r_row, cr && cc && cz, ovf_now, n_cnt, n_sum});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0; r_cnt <= '0; r_ovf <= 1'b0;
            r_row <= '0; r_col <= '0; r_slc <= '0;
        end else if (acc) begin
            if (i_item.last_of_patch) begin
                r_sum <= '0; r_cnt <= '0; r_ovf <= 1'b0;
                if (!cr) begin
                    r_row <= r_row + 1'b1;
                end else begin
                    r_row <= '0;
                    if (!cc) begin
                        r_col <= r_col + 1'b1;
                    end else begin
                        r_col <= '0;
                        r_slc <= cz ? '0 : r_slc + 1'b1;
                    end
                end
            end else begin
                r_sum <= n_sum; r_cnt <= n_cnt; r_ovf <= n_ovf;
            end
        end
    end
endmodule

// ===== hw/rtl/cpwm_queue.sv =====
// ----------------------------------------------------------------------------
// cpwm_queue
// Small FIFO between front and back.
// ----------------------------------------------------------------------------
module cpwm_queue #(
    parameter int W = 64,
    parameter int DEPTH_LOG = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int DEPTH = 1 << DEPTH_LOG;
    logic [W-1:0]         r_mem [DEPTH];
    logic [DEPTH_LOG-1:0] r_wp, r_rp;
    logic [DEPTH_LOG:0]   r_n;

    assign o_full  = r_n == (DEPTH_LOG+1)'(DEPTH);
    assign o_empty = r_n == '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_n <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_n <= r_n + (DEPTH_LOG+1)'(i_push) - (DEPTH_LOG+1)'(i_pop);
        end
    end
endmodule

// ===== hw/rtl/cpwm_back.sv =====
// ----------------------------------------------------------------------------
// cpwm_back
// Stores the cell, walks the causal window through the memories, divides.
// ----------------------------------------------------------------------------
module cpwm_back #(
    parameter int PATCH_W = 10,
    parameter int SUM_W   = 26,
    parameter int POS_W   = 5,
    parameter int WIN_W   = 4,
    parameter int JOB_W   = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  logic [JOB_W-1:0]     i_job,
    output logic                 o_pop,
    input  logic [WIN_W-1:0]     i_win,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cpwm_pkg::t_out_item  o_item
);
    localparam int ADDR_W = 3 * POS_W;
    localparam int TSUM_W = SUM_W + 3 * WIN_W;
    localparam int TCNT_W = PATCH_W + 1 + 3 * WIN_W;
    localparam int VW     = cpwm_pkg::VALUE_W;

    logic [SUM_W-1:0]   j_sum;
    logic [PATCH_W:0]   j_cnt;
    logic               j_ovf, j_last;
    logic [POS_W-1:0]   j_row, j_col, j_slc;
    assign {j_slc, j_col, j_row, j_last, j_ovf, j_cnt, j_sum} =
        i_job[3*POS_W+2+PATCH_W+1+SUM_W-1:0];

    logic [SUM_W-1:0]   r_smem [1 << ADDR_W];
    logic [PATCH_W:0]   r_cmem [1 << ADDR_W];
    logic [SUM_W-1:0]   r_rsum;
    logic [PATCH_W:0]   r_rcnt;

    cpwm_pkg::t_back_state r_st, n_st;
    logic [POS_W-1:0] r_r, r_c, r_z, r_r0, r_c0;
    logic [POS_W-1:0] n_r, n_c, n_z;
    logic [TSUM_W-1:0] r_acc;
    logic [TCNT_W-1:0] r_den;
    logic [VW-1:0]     r_q;
    logic [$clog2(VW+TSUM_W+1)-1:0] r_bit;
    logic              r_rd_ok, r_wr, n_rd, r_ovf, r_lastv;
    logic [TCNT_W-1:0] r_cacc;
    logic [TSUM_W+TCNT_W-1:0] r_divrem;
    logic [WIN_W-1:0] w;
    logic [POS_W-1:0] r_rs, r_cs, r_zs;

    assign w = (i_win == '0) ? WIN_W'(1) : i_win;

    function automatic logic [POS_W-1:0] wstart(input logic [POS_W-1:0] p,
                                                input logic [WIN_W-1:0] wv);
        logic [POS_W:0] pp;
        pp = {1'b0, p} + 1'b1;
        return (pp > (POS_W+1)'(wv)) ? POS_W'(pp - (POS_W+1)'(wv)) : '0;
    endfunction

    // walk: address current (r_r,r_c,r_z); read registered, accumulated next cycle
    always_comb begin
        n_r = r_r; n_c = r_c; n_z = r_z;
        if (r_r != r_rs) begin
            n_r = r_r - 1'b1;
        end else begin
            n_r = r_r0;
            if (r_c != r_cs) begin
                n_c = r_c - 1'b1;
            end else begin
                n_c = r_c0;
                n_z = r_z - 1'b1;
            end
        end
    end

    logic walk_done;
    assign walk_done = (r_r == r_rs) && (r_c == r_cs) && (r_z == r_zs);

    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            r_smem[{r_z, r_c, r_r}] <= r_acc[SUM_W-1:0];
            r_cmem[{r_z, r_c, r_r}] <= r_cacc[PATCH_W:0];
        end
        r_rsum <= r_smem[{r_z, r_c, r_r}];
        r_rcnt <= r_cmem[{r_z, r_c, r_r}];
    end

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        n_rd  = 1'b0;
        case (r_st)
            cpwm_pkg::ST_IDLE: if (!i_empty) begin
                o_pop = 1'b1;
                n_st  = cpwm_pkg::ST_WALK;
            end
            cpwm_pkg::ST_WALK: n_st = cpwm_pkg::ST_ACC;
            cpwm_pkg::ST_ACC: begin
                n_rd = 1'b1;
                if (walk_done) n_st = cpwm_pkg::ST_DIV;
            end
            cpwm_pkg::ST_DIV: if (r_bit == '0 && !r_rd_ok) n_st = cpwm_pkg::ST_OUT;
            cpwm_pkg::ST_OUT: if (!i_stall) n_st = cpwm_pkg::ST_IDLE;
            default: n_st = cpwm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= cpwm_pkg::ST_IDLE;
            r_wr <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_st <= n_st;
            r_wr <= o_pop;
            r_rd_ok <= n_rd && (r_st == cpwm_pkg::ST_ACC);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            cpwm_pkg::ST_IDLE: begin
                r_r <= j_row; r_c <= j_col; r_z <= j_slc;
                r_r0 <= j_row; r_c0 <= j_col;
                r_rs <= wstart(j_row, w); r_cs <= wstart(j_col, w);
                r_zs <= wstart(j_slc, w);
                r_acc <= TSUM_W'(j_sum);
                r_cacc <= TCNT_W'(j_cnt);
                r_ovf <= j_ovf; r_lastv <= j_last;
            end
            cpwm_pkg::ST_WALK: begin
                // own cell just written: start totals from zero, read it back
                r_acc <= '0; r_cacc <= '0;
            end
            cpwm_pkg::ST_ACC: begin
                if (r_rd_ok) begin
                    r_acc <= r_acc + TSUM_W'(r_rsum);
                    r_cacc <= r_cacc + TCNT_W'(r_rcnt);
                end
                if (!walk_done) begin
                    r_r <= n_r; r_c <= n_c; r_z <= n_z;
                end
                r_bit <= ($bits(r_bit))'(TSUM_W);
            end
            cpwm_pkg::ST_DIV: begin
                if (r_rd_ok) begin
                    r_divrem <= {TCNT_W'(0), r_acc + TSUM_W'(r_rsum)};
                    r_den <= r_cacc + TCNT_W'(r_rcnt);
                    r_q <= '0;
                end else if (r_bit != '0) begin
                    r_bit <= r_bit - 1'b1;
                    if ((r_divrem << 1) >= ({r_den, TSUM_W'(0)})) begin
                        r_divrem <= (r_divrem << 1) - {r_den, TSUM_W'(0)};
                        r_q <= {r_q[VW-2:0], 1'b1};
                    end else begin
                        r_divrem <= r_divrem << 1;
                        r_q <= {r_q[VW-2:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_st == cpwm_pkg::ST_OUT;
    assign o_item.voxel_mean     = (r_den == '0) ? '0 : r_q;
    assign o_item.last_voxel     = r_lastv;
    assign o_item.patch_overflow = r_ovf;
endmodule

// ===== hw/rtl/causal_patch_window_mean_3d.sv =====
// ----------------------------------------------------------------------------
// causal_patch_window_mean_3d
// Causal 3D box-filter mean over per-cell patches.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in      | i_ -> blk | cpwm_pkg::t_in_item  (i_valid / o_stall)
// out     | blk -> o_ | cpwm_pkg::t_out_item (o_valid / i_stall)
// cfg     | i_ -> blk | i_cfg_we, i_cfg_idx, i_cfg_data
// One element per cycle is taken while the job queue has room.
// The back end stores each closed patch, sums its window (up to w^3 cells)
// in the one-cell-per-cycle memory walk and divides in the 38-step divider.
// Input stalls while both queue slots hold jobs; i_stall holds the result.
// Reset is synchronous, active low; the cell memories are not cleared.
// ----------------------------------------------------------------------------
module causal_patch_window_mean_3d #(
    parameter int MAX_PATCH_ELEMS = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cpwm_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cpwm_pkg::t_out_item  o_data,
    input  logic                 i_cfg_we,
    input  logic [cpwm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cpwm_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int PATCH_W = $clog2(MAX_PATCH_ELEMS + 1) - 1 < 1 ? 1
                             : $clog2(MAX_PATCH_ELEMS + 1) - 1;
    localparam int SUM_W   = cpwm_pkg::VALUE_W + PATCH_W + 1;
    localparam int POS_W   = 5;
    localparam int WIN_W   = 4;
    localparam int JOB_W   = 3 * POS_W + 2 + PATCH_W + 1 + SUM_W;

    logic [POS_W:0] r_rows, r_cols, r_slices;
    logic [WIN_W-1:0] r_win;
    logic [POS_W:0] rows, cols, slices;
    logic [WIN_W-1:0] win;

    function automatic logic [POS_W:0] cdim(input logic [POS_W:0] v);
        if (v == '0) return (POS_W+1)'(1);
        if (v > (POS_W+1)'(32)) return (POS_W+1)'(32);
        return v;
    endfunction

    assign rows   = cdim(r_rows);
    assign cols   = cdim(r_cols);
    assign slices = cdim(r_slices);
    assign win    = (r_win > WIN_W'(8)) ? WIN_W'(8) : r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 6'd32; r_cols <= 6'd32; r_slices <= 6'd32; r_win <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cpwm_pkg::REG_GRID_ROWS:   r_rows   <= i_cfg_data;
                cpwm_pkg::REG_GRID_COLS:   r_cols   <= i_cfg_data;
                cpwm_pkg::REG_GRID_SLICES: r_slices <= i_cfg_data;
                cpwm_pkg::REG_WINDOW_SIZE: r_win    <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    logic push, full, pop, empty;
    logic [JOB_W-1:0] job_in, job_out;

    cpwm_front #(.PATCH_W(PATCH_W), .SUM_W(SUM_W), .POS_W(POS_W),
                 .MAX_PATCH_ELEMS(MAX_PATCH_ELEMS), .JOB_W(JOB_W)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item(i_data),
        .i_rows(rows), .i_cols(cols), .i_slices(slices),
        .o_push(push), .o_job(job_in), .i_full(full));

    cpwm_queue #(.W(JOB_W), .DEPTH_LOG(1)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data(job_in), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(job_out));

    cpwm_back #(.PATCH_W(PATCH_W), .SUM_W(SUM_W), .POS_W(POS_W),
                .WIN_W(WIN_W), .JOB_W(JOB_W)) u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_job(job_out), .o_pop(pop),
        .i_win(win), .o_valid, .i_stall, .o_item(o_data));

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> o_stall) else $error("full queue not stalling input");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result dropped while stalled");
endmodule
